// File: rtl/core/lxc_pkg.sv
// shared constants, types and helpers for the lab to xyz converter
`timescale 1ns / 1ps

package lxc_pkg;

	localparam int IFRAC         = 16;
	localparam int FRAC_BITS_DEF = 8;

	localparam int LIN_W   = 15;
	localparam int AB_W    = 16;
	localparam int WHITE_W = 16;
	localparam int OUT_W   = 18;

	localparam int ND_W   = 28;
	localparam int V_W    = 22;
	localparam int U_W    = V_W - 1;
	localparam int T_W    = 2 * U_W - IFRAC;
	localparam int C_W    = T_W + U_W - IFRAC;
	localparam int LD_W   = 31;
	localparam int F_W    = 32;
	localparam int PROD_W = F_W + WHITE_W + 1;

	localparam int DIV_Y   = 116;
	localparam int DIV_A   = 500;
	localparam int DIV_B   = 200;
	localparam int DIV_LIN = 7787;
	localparam int LIN_MUL = 1000;

	localparam int Y_OFFSET   = 16 << IFRAC;
	localparam int OFFSET_Q16 = 9039;
	localparam int THRESH_Q16 = 580;
	localparam int RND_HALF   = 1 << (IFRAC - 1);

	localparam int OUT_MIN = -32768;
	localparam int OUT_MAX = 131071;

	localparam logic [WHITE_W-1:0] WHITE_X_RST = WHITE_W'(24332);
	localparam logic [WHITE_W-1:0] WHITE_Y_RST = WHITE_W'(25600);
	localparam logic [WHITE_W-1:0] WHITE_Z_RST = WHITE_W'(27874);

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_X = 2'd0,
		REG_WHITE_Y = 2'd1,
		REG_WHITE_Z = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} lane_en_t;

	// round half away from zero by 2^IFRAC, then clip to the output range
	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] r;
		logic signed [OUT_W-1:0]  res;
		bias = PROD_W'(RND_HALF) - PROD_W'(p[PROD_W-1]);
		r = (p + bias) >>> IFRAC;
		if (r > PROD_W'(OUT_MAX))
			res = OUT_W'(OUT_MAX);
		else if (r < PROD_W'(OUT_MIN))
			res = OUT_W'(OUT_MIN);
		else
			res = OUT_W'(r);
		return res;
	endfunction

endpackage

// File: rtl/core/lxc_cdiv.sv
// registered unsigned floor division by a constant through a reciprocal multiply
`timescale 1ns / 1ps

module lxc_cdiv #(
	parameter int W = lxc_pkg::ND_W,
	parameter int D = lxc_pkg::DIV_Y
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] m,
	output logic [W-1:0] q
);
	import lxc_pkg::*;

	localparam int K = W + $clog2(D);
	localparam longint unsigned MAGIC = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
	localparam logic [W:0] M = (W+1)'(MAGIC);

	logic [2*W:0] prod;

	assign prod = (2*W+1)'(m) * (2*W+1)'(M);

	always_ff @(posedge clk) begin
		if (en) begin
			q <= W'(prod >> K);
		end
	end

endmodule

// File: rtl/core/lxc_lane.sv
// one colour channel: cube or linear branch, then reference white scaling
`timescale 1ns / 1ps

module lxc_lane (
	input  logic                               clk,
	input  lxc_pkg::lane_en_t                  en,
	input  logic signed [lxc_pkg::V_W-1:0]     v,
	input  logic [lxc_pkg::WHITE_W-1:0]        white,
	output logic signed [lxc_pkg::PROD_W-1:0]  prod_s7
);
	import lxc_pkg::*;

	logic               pos;
	logic [U_W-1:0]     u;
	logic [2*U_W-1:0]   sq;
	logic signed [V_W:0] d;
	logic [V_W:0]       dmag;

	logic               pos_s4;
	logic               dneg_s4;
	logic [U_W-1:0]     u_s4;
	logic [T_W-1:0]     t_s4;
	logic [LD_W-1:0]    m_s4;

	logic [T_W+U_W-1:0] cube;
	logic               pos_s5;
	logic               dneg_s5;
	logic [C_W-1:0]     c_s5;
	logic [LD_W-1:0]    q_lin_s5;

	logic               cubic;
	logic signed [F_W-1:0] lin;
	logic signed [F_W-1:0] f_s6;

	assign pos  = !v[V_W-1] && (v != '0);
	assign u    = v[U_W-1:0];
	assign sq   = (2*U_W)'(u) * (2*U_W)'(u);
	assign d    = (V_W+1)'(v) - (V_W+1)'(OFFSET_Q16);
	assign dmag = d[V_W] ? (V_W+1)'(-d) : (V_W+1)'(d);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pos_s4  <= pos;
			dneg_s4 <= d[V_W];
			u_s4    <= u;
			t_s4    <= sq[IFRAC +: T_W];
			m_s4    <= LD_W'(dmag) * LD_W'(LIN_MUL) + LD_W'(DIV_LIN / 2);
		end
	end

	lxc_cdiv #(
		.W(LD_W),
		.D(DIV_LIN)
	) u_div_lin (
		.clk(clk),
		.en (en.s5),
		.m  (m_s4),
		.q  (q_lin_s5)
	);

	assign cube = (T_W+U_W)'(t_s4) * (T_W+U_W)'(u_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			pos_s5  <= pos_s4;
			dneg_s5 <= dneg_s4;
			c_s5    <= cube[IFRAC +: C_W];
		end
	end

	assign cubic = pos_s5 && (c_s5 > C_W'(THRESH_Q16));
	assign lin   = dneg_s5 ? -F_W'(q_lin_s5) : F_W'(q_lin_s5);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			f_s6 <= cubic ? F_W'(c_s5) : lin;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			prod_s7 <= PROD_W'(f_s6) * PROD_W'($signed({1'b0, white}));
		end
	end

endmodule

// File: rtl/core/lab_to_xyz_converter.sv
// top level: cie l*a*b* to xyz converter with three channel lanes
// Takes one L*a*b* pixel per clock and returns X, Y, Z with FRAC_BITS fraction bits,
// saturated to -32768..131071. The datapath is an eight-stage pipeline: input
// register, constant dividers for (L+16)/116, a/500 and b/200, the skew adders,
// then three lanes (square, cube and linear-branch divide, select, white multiply)
// and an output register that rounds and saturates. Throughput is one item per
// clock while out_ready is high, and bubbles are squeezed out when the output
// stalls. The white registers are read in the last lane stage, so the user must
// write them only while no item is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module lab_to_xyz_converter #(
	parameter int FRAC_BITS = lxc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lxc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lxc_pkg::WHITE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lxc_pkg::LIN_W-1:0]           lightness,
	input  logic signed [lxc_pkg::AB_W-1:0]     green_red,
	input  logic signed [lxc_pkg::AB_W-1:0]     blue_yellow,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lxc_pkg::OUT_W-1:0]    out_x,
	output logic signed [lxc_pkg::OUT_W-1:0]    out_y,
	output logic signed [lxc_pkg::OUT_W-1:0]    out_z
);
	import lxc_pkg::*;

	localparam int SHIFT   = IFRAC - FRAC_BITS;
	localparam int NSTAGES = 7;

	logic [WHITE_W-1:0] white_x_q;
	logic [WHITE_W-1:0] white_y_q;
	logic [WHITE_W-1:0] white_z_q;

	logic [NSTAGES-1:0] vld_q;
	logic               out_valid_q;
	logic [NSTAGES:0]   en;
	lane_en_t           lane_en;

	logic [AB_W-1:0]    mag_a;
	logic [AB_W-1:0]    mag_b;

	logic [ND_W-1:0]    ny_s1;
	logic [ND_W-1:0]    na_s1;
	logic [ND_W-1:0]    nb_s1;
	logic               sa_s1;
	logic               sb_s1;

	logic [ND_W-1:0]    qy_s2;
	logic [ND_W-1:0]    qa_s2;
	logic [ND_W-1:0]    qb_s2;
	logic               sa_s2;
	logic               sb_s2;

	logic signed [V_W-1:0] vy;
	logic signed [V_W-1:0] va;
	logic signed [V_W-1:0] vb;
	logic signed [V_W-1:0] vx_s3;
	logic signed [V_W-1:0] vy_s3;
	logic signed [V_W-1:0] vz_s3;

	logic signed [PROD_W-1:0] px_s7;
	logic signed [PROD_W-1:0] py_s7;
	logic signed [PROD_W-1:0] pz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= WHITE_X_RST;
			white_y_q <= WHITE_Y_RST;
			white_z_q <= WHITE_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHITE_X: white_x_q <= cfg_data;
				REG_WHITE_Y: white_y_q <= cfg_data;
				REG_WHITE_Z: white_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[NSTAGES] = !out_valid_q || out_ready;
		for (int k = NSTAGES - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NSTAGES; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
			if (en[NSTAGES])
				out_valid_q <= vld_q[NSTAGES-1];
		end
	end

	assign mag_a = green_red[AB_W-1] ? AB_W'(-green_red) : AB_W'(green_red);
	assign mag_b = blue_yellow[AB_W-1] ? AB_W'(-blue_yellow) : AB_W'(blue_yellow);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ny_s1 <= (ND_W'(lightness) << SHIFT) + ND_W'(Y_OFFSET + DIV_Y / 2);
			na_s1 <= (ND_W'(mag_a) << SHIFT) + ND_W'(DIV_A / 2);
			nb_s1 <= (ND_W'(mag_b) << SHIFT) + ND_W'(DIV_B / 2);
			sa_s1 <= green_red[AB_W-1];
			sb_s1 <= blue_yellow[AB_W-1];
		end
	end

	lxc_cdiv #(.W(ND_W), .D(DIV_Y)) u_div_y (
		.clk(clk), .en(en[1]), .m(ny_s1), .q(qy_s2)
	);

	lxc_cdiv #(.W(ND_W), .D(DIV_A)) u_div_a (
		.clk(clk), .en(en[1]), .m(na_s1), .q(qa_s2)
	);

	lxc_cdiv #(.W(ND_W), .D(DIV_B)) u_div_b (
		.clk(clk), .en(en[1]), .m(nb_s1), .q(qb_s2)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sa_s2 <= sa_s1;
			sb_s2 <= sb_s1;
		end
	end

	assign vy = V_W'(qy_s2);
	assign va = V_W'(qa_s2);
	assign vb = V_W'(qb_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vy_s3 <= vy;
			vx_s3 <= sa_s2 ? vy - va : vy + va;
			vz_s3 <= sb_s2 ? vy + vb : vy - vb;
		end
	end

	assign lane_en.s4 = en[3];
	assign lane_en.s5 = en[4];
	assign lane_en.s6 = en[5];
	assign lane_en.s7 = en[6];

	lxc_lane u_lane_x (
		.clk(clk), .en(lane_en), .v(vx_s3), .white(white_x_q), .prod_s7(px_s7)
	);

	lxc_lane u_lane_y (
		.clk(clk), .en(lane_en), .v(vy_s3), .white(white_y_q), .prod_s7(py_s7)
	);

	lxc_lane u_lane_z (
		.clk(clk), .en(lane_en), .v(vz_s3), .white(white_z_q), .prod_s7(pz_s7)
	);

	// merge the three lanes into the output item
	always_ff @(posedge clk) begin
		if (en[NSTAGES]) begin
			out_x <= round_sat(px_s7);
			out_y <= round_sat(py_s7);
			out_z <= round_sat(pz_s7);
		end
	end

`ifndef SYNTH
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_x >= OUT_W'(OUT_MIN)) && (out_y >= OUT_W'(OUT_MIN))
			&& (out_z >= OUT_W'(OUT_MIN)))
		else $error("output below saturation floor");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	a_taken_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is taken");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted into a full pipeline");

	a_pipe_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_ready && out_valid_q |=>
			$countones(vld_q) >= 1)
		else $error("accepted item lost in pipeline");
`endif

endmodule
